// ===== sv/ise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg
// Shared constants and types for the integer stack engine.
// ----------------------------------------------------------------------------
package ise_pkg;

   localparam int DEPTH    = 32;
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W    = CNT_W + 1;

   localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PALL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_PRINT
   } ctrl_state_type;

   // operation broadcast from the controller to the cell chain
   typedef enum logic [2:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP,
      STK_SWAP,
      STK_ROT
   } stk_op_type;

   // what one cell loads this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PREV,
      CELL_NEXT,
      CELL_ROT
   } cell_op_type;

   // stack view seen by the controller
   typedef struct packed {
      logic [DEPTH-1:0]         occ;
      logic signed [DATA_W-1:0] head;
   } stack_view_type;

endpackage

// ===== sv/ise_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_ifs
// Request and response channels of the integer stack engine.
// ----------------------------------------------------------------------------
interface ise_req_if;
   logic                               valid;
   logic                               ready;
   logic [ise_pkg::CMD_W-1:0]          cmd;
   logic signed [ise_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface ise_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ise_pkg::DATA_W-1:0]  value;
   logic                               has_value;
   logic [ise_pkg::STATUS_W-1:0]       status;
   logic                               last;

   modport source (output valid, output value, output has_value, output status,
                   output last, input ready);
   modport sink   (input valid, input value, input has_value, input status,
                   input last, output ready);
endinterface

// ===== sv/ise_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_cell
// One stack slot: holds an entry and its occupancy, loads from a neighbour.
// ----------------------------------------------------------------------------
module ise_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  ise_pkg::cell_op_type              op,
   input  logic signed [ise_pkg::DATA_W-1:0] prev_data,
   input  logic                              prev_valid,
   input  logic signed [ise_pkg::DATA_W-1:0] next_data,
   input  logic                              next_valid,
   input  logic signed [ise_pkg::DATA_W-1:0] head_data,
   output logic signed [ise_pkg::DATA_W-1:0] data_out,
   output logic                              valid_out
);

   logic signed [ise_pkg::DATA_W-1:0] data_ff, data_in;
   logic                              valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (op)
         ise_pkg::CELL_PREV: begin
            data_in  = prev_data;
            valid_in = prev_valid;
         end
         ise_pkg::CELL_NEXT: begin
            data_in  = next_data;
            valid_in = next_valid;
         end
         ise_pkg::CELL_ROT: begin
            // bottom occupied cell wraps round to the head
            if (valid_ff) begin
               data_in = next_valid ? next_data : head_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;

endmodule

// ===== sv/ise_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_ctrl
// Command decode, print sequencer and registered response beat.
// ----------------------------------------------------------------------------
module ise_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   ise_req_if.sink                 req_chan,
   ise_rsp_if.source               rsp_chan,
   input  ise_pkg::stack_view_type view,
   output ise_pkg::stk_op_type     stk_op
);

   ise_pkg::ctrl_state_type state_ff, state_in;
   logic [ise_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ise_pkg::DATA_W-1:0] value_ff, value_in;
   logic                              has_ff, has_in;
   logic [ise_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              last_ff, last_in;

   logic                        slot_free;
   logic                        accept;
   logic                        empty;
   logic                        lt_two;
   logic                        full;
   logic                        head_last;
   logic [ise_pkg::DEPTH:0]     occ_ext;
   logic [ise_pkg::IDX_W-1:0]   nxt_idx;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   // no request beat is taken while reset is held
   assign req_chan.ready = !reset && (state_ff == ise_pkg::ST_IDLE) && slot_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign empty   = !view.occ[0];
   assign lt_two  = !view.occ[1];
   assign full    = view.occ[ise_pkg::DEPTH-1];
   assign occ_ext = {1'b0, view.occ};
   // head holds the bottom entry once the slot after the print count is empty
   assign nxt_idx   = {1'b0, cnt_ff} + ise_pkg::IDX_W'(1);
   assign head_last = !occ_ext[nxt_idx];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      value_in     = value_ff;
      has_in       = has_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      stk_op       = ise_pkg::STK_HOLD;
      case (state_ff)
         ise_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               value_in     = '0;
               has_in       = 1'b0;
               status_in    = ise_pkg::STATUS_OK;
               last_in      = 1'b1;
               case (req_chan.cmd)
                  ise_pkg::CMD_PUSH: begin
                     if (full) begin
                        status_in = ise_pkg::STATUS_FULL;
                     end else begin
                        stk_op = ise_pkg::STK_PUSH;
                     end
                  end
                  ise_pkg::CMD_PALL: begin
                     if (!empty) begin
                        value_in = view.head;
                        has_in   = 1'b1;
                        last_in  = head_last;
                        stk_op   = ise_pkg::STK_ROT;
                        if (!head_last) begin
                           state_in = ise_pkg::ST_PRINT;
                           cnt_in   = ise_pkg::CNT_W'(1);
                        end
                     end
                  end
                  ise_pkg::CMD_PEEK: begin
                     if (empty) begin
                        status_in = ise_pkg::STATUS_SHORT;
                     end else begin
                        value_in = view.head;
                        has_in   = 1'b1;
                     end
                  end
                  ise_pkg::CMD_POP: begin
                     if (empty) begin
                        status_in = ise_pkg::STATUS_SHORT;
                     end else begin
                        stk_op = ise_pkg::STK_POP;
                     end
                  end
                  ise_pkg::CMD_SWAP: begin
                     if (lt_two) begin
                        status_in = ise_pkg::STATUS_SHORT;
                     end else begin
                        stk_op = ise_pkg::STK_SWAP;
                     end
                  end
                  default: begin
                     // unknown command: no beat
                     rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                     value_in     = value_ff;
                     has_in       = has_ff;
                     status_in    = status_ff;
                     last_in      = last_ff;
                  end
               endcase
            end
         end
         ise_pkg::ST_PRINT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               value_in     = view.head;
               has_in       = 1'b1;
               status_in    = ise_pkg::STATUS_OK;
               last_in      = head_last;
               stk_op       = ise_pkg::STK_ROT;
               if (head_last) begin
                  state_in = ise_pkg::ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + ise_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ise_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ise_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      has_ff    <= has_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = value_ff;
   assign rsp_chan.has_value = has_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.last      = last_ff;

endmodule

// ===== sv/integer_stack_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_stack_engine_core
// Bounded LIFO of signed words built as a chain of cells, top in cell 0.
// ----------------------------------------------------------------------------
// The response beat is registered and appears in the cycle after the request beat.
// Push, pop, peek and swap: one request per cycle when the response is taken.
// Print all: one response beat per entry; the chain rotates one place per beat and
// is back in order after the last one. No request is taken meanwhile.
// Reset clears the occupancy bits and controller at once; no clearing pass.
// ----------------------------------------------------------------------------
module integer_stack_engine_core (
   input  logic      clock,
   input  logic      reset,
   ise_req_if.sink   req_chan,
   ise_rsp_if.source rsp_chan
);

   logic signed [ise_pkg::DATA_W-1:0] cell_data [ise_pkg::DEPTH];
   logic [ise_pkg::DEPTH-1:0]         cell_valid;
   ise_pkg::stk_op_type               stk_op;
   ise_pkg::stack_view_type           view;

   assign view.occ  = cell_valid;
   assign view.head = cell_data[0];

   ise_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .view     (view),
      .stk_op   (stk_op)
   );

   for (genvar i = 0; i < ise_pkg::DEPTH; i++) begin : g_cell
      ise_pkg::cell_op_type              op;
      logic signed [ise_pkg::DATA_W-1:0] prev_data;
      logic                              prev_valid;
      logic signed [ise_pkg::DATA_W-1:0] next_data;
      logic                              next_valid;

      always_comb begin
         case (stk_op)
            ise_pkg::STK_PUSH: op = ise_pkg::CELL_PREV;
            ise_pkg::STK_POP:  op = ise_pkg::CELL_NEXT;
            ise_pkg::STK_ROT:  op = ise_pkg::CELL_ROT;
            ise_pkg::STK_SWAP: begin
               if (i == 0) begin
                  op = ise_pkg::CELL_NEXT;
               end else if (i == 1) begin
                  op = ise_pkg::CELL_PREV;
               end else begin
                  op = ise_pkg::CELL_HOLD;
               end
            end
            default: op = ise_pkg::CELL_HOLD;
         endcase
      end

      if (i == 0) begin : g_top
         assign prev_data  = req_chan.push_value;
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_data  = cell_data[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      if (i == ise_pkg::DEPTH-1) begin : g_bot
         assign next_data  = '0;
         assign next_valid = 1'b0;
      end else begin : g_low
         assign next_data  = cell_data[i+1];
         assign next_valid = cell_valid[i+1];
      end

      ise_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .prev_data  (prev_data),
         .prev_valid (prev_valid),
         .next_data  (next_data),
         .next_valid (next_valid),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[i]),
         .valid_out  (cell_valid[i])
      );
   end

   // occupancy is always a contiguous run from the top cell
   a_occ_contig : assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("stack occupancy not contiguous");

   a_push_head : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == ise_pkg::CMD_PUSH
       && !cell_valid[ise_pkg::DEPTH-1])
      |=> (cell_valid[0] && cell_data[0] == $past(req_chan.push_value)))
      else $error("pushed word not at head");

   a_pop_shrink : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == ise_pkg::CMD_POP
       && cell_valid[0])
      |=> (cell_valid == ($past(cell_valid) >> 1)))
      else $error("pop did not drop one entry");

   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while response beat stalled");

endmodule

// ===== tb/tb_integer_stack_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_stack_engine_core
// Self-checking bench for the integer stack engine: a shadow stack predicts
// every response beat, which is checked in order, under random idling.
// ----------------------------------------------------------------------------
module tb_integer_stack_engine_core;

   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [ise_pkg::CMD_W-1:0] CMD_TOP_CODE = '1;

   typedef struct {
      logic signed [ise_pkg::DATA_W-1:0] value;
      logic                              has_value;
      logic [ise_pkg::STATUS_W-1:0]      status;
      logic                              last;
   } stack_reply_type;

   logic clock = 1'b0;
   logic reset;

   ise_req_if req_bus ();
   ise_rsp_if rsp_bus ();

   integer_stack_engine_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #4 clock = ~clock;

   // shadow of the stack, bottom at index 0
   logic signed [ise_pkg::DATA_W-1:0] shadow_stack [ise_pkg::DEPTH];
   int                                shadow_fill = 0;
   stack_reply_type                   stack_replies_due [$];

   int send_idle_pct = 24;
   int rsp_stall_pct = 88;
   int mismatch_count = 0;
   int cycle_count = 0;

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s", msg);
   endfunction

   function automatic void apply_stack_command(
      input logic [ise_pkg::CMD_W-1:0]         cmd,
      input logic signed [ise_pkg::DATA_W-1:0] val);
      stack_reply_type                   r;
      logic signed [ise_pkg::DATA_W-1:0] t;
      r = '{value: '0, has_value: 1'b0, status: ise_pkg::STATUS_OK, last: 1'b1};
      case (cmd)
         ise_pkg::CMD_PUSH: begin
            if (shadow_fill >= ise_pkg::DEPTH) begin
               r.status = ise_pkg::STATUS_FULL;
            end else begin
               shadow_stack[shadow_fill] = val;
               shadow_fill++;
            end
            stack_replies_due.push_back(r);
         end
         ise_pkg::CMD_PALL: begin
            if (shadow_fill == 0) begin
               stack_replies_due.push_back(r);
            end else begin
               // top first, last flag on the bottom entry
               for (int k = shadow_fill - 1; k >= 0; k--) begin
                  r.value     = shadow_stack[k];
                  r.has_value = 1'b1;
                  r.last      = (k == 0);
                  stack_replies_due.push_back(r);
               end
            end
         end
         ise_pkg::CMD_PEEK: begin
            if (shadow_fill == 0) begin
               r.status = ise_pkg::STATUS_SHORT;
            end else begin
               r.value     = shadow_stack[shadow_fill-1];
               r.has_value = 1'b1;
            end
            stack_replies_due.push_back(r);
         end
         ise_pkg::CMD_POP: begin
            if (shadow_fill == 0) r.status = ise_pkg::STATUS_SHORT;
            else shadow_fill--;
            stack_replies_due.push_back(r);
         end
         ise_pkg::CMD_SWAP: begin
            if (shadow_fill < 2) begin
               r.status = ise_pkg::STATUS_SHORT;
            end else begin
               t                           = shadow_stack[shadow_fill-1];
               shadow_stack[shadow_fill-1] = shadow_stack[shadow_fill-2];
               shadow_stack[shadow_fill-2] = t;
            end
            stack_replies_due.push_back(r);
         end
         default: ; // unknown codes are dropped without a response
      endcase
   endfunction

   // one request beat; valid stays high into the next call when there is no gap
   task automatic send_stack_command(input logic [ise_pkg::CMD_W-1:0]         cmd,
                                     input logic signed [ise_pkg::DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.push_value <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_stack_command(cmd, val);
   endtask

   task automatic wait_for_replies;
      req_bus.valid <= 1'b0;
      while (stack_replies_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [ise_pkg::DATA_W-1:0] random_word;
      case ($urandom_range(7))
         0:       return {1'b1, {(ise_pkg::DATA_W-1){1'b0}}};
         1:       return {1'b0, {(ise_pkg::DATA_W-1){1'b1}}};
         2:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed_corners;
      send_stack_command(ise_pkg::CMD_PALL, 32'sd0);
      send_stack_command(ise_pkg::CMD_PEEK, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);
      send_stack_command(ise_pkg::CMD_SWAP, 32'sd0);
      send_stack_command(ise_pkg::CMD_SWAP + 3'd1, '1);
      send_stack_command(ise_pkg::CMD_SWAP + 3'd2, 32'sh5a5a_a5a5);
      send_stack_command(CMD_TOP_CODE, '1);
      send_stack_command(ise_pkg::CMD_PUSH, {1'b1, {(ise_pkg::DATA_W-1){1'b0}}});
      send_stack_command(ise_pkg::CMD_SWAP, 32'sd0);   // single entry: too short
      send_stack_command(ise_pkg::CMD_PUSH, {1'b0, {(ise_pkg::DATA_W-1){1'b1}}});
      send_stack_command(ise_pkg::CMD_PUSH, 32'sd0);
      send_stack_command(ise_pkg::CMD_PUSH, -32'sd1);
      send_stack_command(ise_pkg::CMD_PEEK, 32'sd0);
      send_stack_command(ise_pkg::CMD_SWAP, 32'sd0);
      send_stack_command(ise_pkg::CMD_PEEK, 32'sd0);
      send_stack_command(ise_pkg::CMD_PALL, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);
      send_stack_command(ise_pkg::CMD_PEEK, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);
      send_stack_command(ise_pkg::CMD_POP, 32'sd0);   // empty again
      wait_for_replies();
   endtask

   task automatic test_full_stack;
      while (shadow_fill < ise_pkg::DEPTH)
         send_stack_command(ise_pkg::CMD_PUSH, random_word());
      send_stack_command(ise_pkg::CMD_PUSH, random_word());
      send_stack_command(ise_pkg::CMD_PUSH, random_word());
      send_stack_command(ise_pkg::CMD_PEEK, random_word());
      send_stack_command(ise_pkg::CMD_SWAP, random_word());
      send_stack_command(ise_pkg::CMD_PEEK, random_word());
      send_stack_command(ise_pkg::CMD_PALL, random_word());
      while (shadow_fill > 0) send_stack_command(ise_pkg::CMD_POP, random_word());
      send_stack_command(ise_pkg::CMD_POP, random_word());
      wait_for_replies();
   endtask

   task automatic test_random_mix(input int n_items);
      int                          r;
      int                          push_pct;
      logic [ise_pkg::CMD_W-1:0]   cmd;
      repeat (n_items) begin
         r        = $urandom_range(99);
         push_pct = (shadow_fill < ise_pkg::DEPTH / 2) ? 50 : 35;
         if (r < 4)
            cmd = ise_pkg::CMD_W'($urandom_range(CMD_TOP_CODE, ise_pkg::CMD_SWAP + 1));
         else if (r < 4 + push_pct)      cmd = ise_pkg::CMD_PUSH;
         else if (r < 12 + push_pct)     cmd = ise_pkg::CMD_PALL;
         else if (r < 22 + push_pct)     cmd = ise_pkg::CMD_PEEK;
         else if (r < 34 + push_pct)     cmd = ise_pkg::CMD_SWAP;
         else                            cmd = ise_pkg::CMD_POP;
         send_stack_command(cmd, random_word());
      end
      wait_for_replies();
   endtask

   // response side: random stalls, in-order check against the shadow
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else       rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      stack_reply_type r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (stack_replies_due.size() == 0) begin
            note_mismatch($sformatf("unexpected beat value=%0d has=%0b status=%0d last=%0b",
                                    rsp_bus.value, rsp_bus.has_value, rsp_bus.status,
                                    rsp_bus.last));
         end else begin
            r = stack_replies_due.pop_front();
            if (rsp_bus.value !== r.value || rsp_bus.has_value !== r.has_value ||
                rsp_bus.status !== r.status || rsp_bus.last !== r.last)
               note_mismatch({
                  $sformatf("exp value=%0d has=%0b status=%0d last=%0b, ",
                            r.value, r.has_value, r.status, r.last),
                  $sformatf("got value=%0d has=%0b status=%0d last=%0b",
                            rsp_bus.value, rsp_bus.has_value, rsp_bus.status,
                            rsp_bus.last)});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = ise_pkg::CMD_PUSH;
      req_bus.push_value = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_full_stack();
      test_random_mix(90);

      send_idle_pct = 88;
      rsp_stall_pct = 24;
      test_random_mix(90);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_mix(90);

      wait_for_replies();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && stack_replies_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ise_pkg.sv
sv/ise_ifs.sv
sv/ise_cell.sv
sv/ise_ctrl.sv
sv/integer_stack_engine_core.sv
tb/tb_integer_stack_engine_core.sv
